[rtl/fpss_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the farthest-point seed selection block.
package fpss_pkg;

  localparam int unsigned NumCoords = 4;
  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned NumPtsW   = 9;
  localparam int unsigned NumSelW   = 4;
  localparam int unsigned IndexOutW = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  localparam logic REG_NUM_POINTS = 1'b0;
  localparam logic REG_NUM_SELECT = 1'b1;

endpackage

[rtl/fpss_dist.sv]
`timescale 1ns / 1ps
// Shared distance unit: squared differences one coordinate a cycle, then a bit-serial root.
module fpss_dist #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               start_i,
  input  logic [fpss_pkg::NumCoords*COORD_BITS-1:0]          a_i,
  input  logic [fpss_pkg::NumCoords*COORD_BITS-1:0]          b_i,
  output logic                                               done_o,
  output logic [((2*COORD_BITS+4 > 64) ? 32 : COORD_BITS+2)-1:0] dist_o
);

  localparam int unsigned SW  = (2 * COORD_BITS + 4 > 64) ? 64 : 2 * COORD_BITS + 4;
  localparam int unsigned RW  = SW / 2;
  localparam int unsigned RMW = RW + 2;
  localparam int unsigned NIT = RW;
  localparam int unsigned CW  = $clog2(NIT + 1);
  localparam int unsigned MW  = 2 * (COORD_BITS + 1);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_SQ   = 2'd1;
  localparam logic [1:0] U_RT   = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CW-1:0]          cnt_q;
  logic [SW-1:0]          prod_q, acc_q, acc_d, rad_q;
  logic [RMW-1:0]         rem_q, rem_n, trial;
  logic [RW-1:0]          root_q;
  logic                   done_q;
  logic [1:0]             csel;
  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0]    mag;
  logic [MW-1:0]          mprod;
  logic [SW-1:0]          sq;
  logic [SW:0]            acc_sum;

  assign csel = cnt_q[1:0];

  always_comb begin
    diff  = $signed({a_i[csel*COORD_BITS + COORD_BITS-1], a_i[csel*COORD_BITS +: COORD_BITS]})
          - $signed({b_i[csel*COORD_BITS + COORD_BITS-1], b_i[csel*COORD_BITS +: COORD_BITS]});
    mag   = diff[COORD_BITS] ? $unsigned(-diff) : $unsigned(diff);
    mprod = MW'(mag) * MW'(mag);
    if (65'(mag) > 65'h0_FFFF_FFFF) begin
      sq = '1;
    end else begin
      sq = SW'(mprod);
    end
  end

  // Saturating accumulate of the registered square.
  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, prod_q};
    acc_d   = acc_sum[SW] ? '1 : acc_sum[SW-1:0];
  end

  assign rem_n = {rem_q[RMW-3:0], rad_q[SW-1:SW-2]};
  assign trial = {root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE:  if (start_i) state_d = U_SQ;
      U_SQ:    if (cnt_q == CW'(4)) state_d = U_RT;
      U_RT:    if (cnt_q == CW'(NIT - 1)) state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == U_RT) && (cnt_q == CW'(NIT - 1));
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: begin
        acc_q <= '0;
      end
      U_SQ: begin
        if (cnt_q < CW'(4)) prod_q <= sq;
        if (cnt_q != '0) acc_q <= acc_d;
        if (cnt_q == CW'(4)) begin
          rad_q  <= acc_d;
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      U_RT: begin
        rad_q <= rad_q << 2;
        if (rem_n >= trial) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[RW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[RW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign dist_o = root_q;

endmodule

[rtl/farthest_point_seed_select_core.sv]
`timescale 1ns / 1ps
// Farthest-point seed selection: point store, search sequencer and seed output.
// A load word is taken whenever the sequencer is idle; loads may stream back to back.
// A run is paced by the one shared distance unit, which sums the four squared differences
// and then forms one root bit a cycle.
// Seeds leave one per cycle through an output register while the sink is ready.
// Reset clears the load count, the sequencer and the configuration to 150 points, 3 seeds.
module farthest_point_seed_select_core #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned MAX_SEEDS  = 8,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [fpss_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operation_i,
  input  logic signed [COORD_BITS-1:0]         in_x_i,
  input  logic signed [COORD_BITS-1:0]         in_y_i,
  input  logic signed [COORD_BITS-1:0]         in_z_i,
  input  logic signed [COORD_BITS-1:0]         in_w_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fpss_pkg::IndexOutW-1:0]       point_index_o,
  output logic signed [COORD_BITS-1:0]         out_x_o,
  output logic signed [COORD_BITS-1:0]         out_y_o,
  output logic signed [COORD_BITS-1:0]         out_z_o,
  output logic signed [COORD_BITS-1:0]         out_w_o,
  output logic                                 last_of_run_o
);

  localparam int unsigned PW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW   = $clog2(MAX_POINTS);
  localparam int unsigned KW   = $clog2(MAX_SEEDS + 1);
  localparam int unsigned SIW  = $clog2(MAX_SEEDS);
  localparam int unsigned PTW  = fpss_pkg::NumCoords * COORD_BITS;
  localparam int unsigned RW   = (2 * COORD_BITS + 4 > 64) ? 32 : COORD_BITS + 2;
  localparam int unsigned SMW  = RW + SIW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_CAP0 = 4'd2;
  localparam logic [3:0] S_RDP  = 4'd3;
  localparam logic [3:0] S_CAND = 4'd4;
  localparam logic [3:0] S_DST  = 4'd5;
  localparam logic [3:0] S_DWT  = 4'd6;
  localparam logic [3:0] S_NEXT = 4'd7;
  localparam logic [3:0] S_RDB  = 4'd8;
  localparam logic [3:0] S_CAPB = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  logic [3:0]                   state_q;
  logic [fpss_pkg::NumPtsW-1:0] num_points_q;
  logic [fpss_pkg::NumSelW-1:0] num_select_q;
  logic [PW-1:0]                load_cnt_q, n_eff;
  logic [KW-1:0]                k_eff;

  logic [PTW-1:0]               mem [MAX_POINTS];
  logic [PTW-1:0]               rd_q;
  logic                         rd_en;
  logic [IW-1:0]                rd_addr;

  logic [PTW-1:0]               seed_crd_q [MAX_SEEDS];
  logic [IW-1:0]                seed_idx_q [MAX_SEEDS];
  logic [SIW-1:0]               seed_sel;
  logic [PTW-1:0]               seed_crd;

  logic [PTW-1:0]               cand_q;
  logic [IW-1:0]                i_q, bidx_q;
  logic [SIW-1:0]               s_q, j_q, e_q;
  logic [SMW-1:0]               sum_q, best_q;

  logic                         dist_start, dist_done;
  logic [RW-1:0]                dist_val;
  logic                         in_acc, out_load, e_last;

  always_comb begin
    if (num_points_q == '0) begin
      n_eff = PW'(1);
    end else if (32'(num_points_q) > 32'(MAX_POINTS)) begin
      n_eff = PW'(MAX_POINTS);
    end else begin
      n_eff = PW'(num_points_q);
    end
    if (num_select_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(num_select_q) > 32'(MAX_SEEDS)) begin
      k_eff = KW'(MAX_SEEDS);
    end else begin
      k_eff = KW'(num_select_q);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_EMIT) && (!out_valid_o || out_ready_i);
  assign e_last     = ({1'b0, e_q} == (SIW+1)'(k_eff - KW'(1)));

  // One read port on the seed registers, shared by the search and the output.
  assign seed_sel = (state_q == S_EMIT) ? e_q : j_q;
  assign seed_crd = seed_crd_q[seed_sel];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_q)
      S_RD0:   rd_en = 1'b1;
      S_RDP: begin
        rd_en   = 1'b1;
        rd_addr = i_q;
      end
      S_RDB: begin
        rd_en   = 1'b1;
        rd_addr = bidx_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (operation_i == fpss_pkg::OP_LOAD) && (32'(load_cnt_q) < 32'(MAX_POINTS))) begin
      mem[load_cnt_q[IW-1:0]] <= {in_w_i, in_z_i, in_y_i, in_x_i};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign dist_start = (state_q == S_DST);

  fpss_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .a_i     (cand_q),
    .b_i     (seed_crd),
    .done_o  (dist_done),
    .dist_o  (dist_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      num_points_q <= fpss_pkg::NumPtsW'(150);
      num_select_q <= fpss_pkg::NumSelW'(3);
      load_cnt_q   <= '0;
      out_valid_o  <= 1'b0;
      s_q          <= '0;
      j_q          <= '0;
      e_q          <= '0;
      i_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fpss_pkg::REG_NUM_POINTS: num_points_q <= cfg_data_i[fpss_pkg::NumPtsW-1:0];
          fpss_pkg::REG_NUM_SELECT: num_select_q <= cfg_data_i[fpss_pkg::NumSelW-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (operation_i == fpss_pkg::OP_RUN) begin
              state_q <= S_RD0;
              s_q     <= SIW'(1);
            end else if (32'(load_cnt_q) < 32'(MAX_POINTS)) begin
              load_cnt_q <= load_cnt_q + PW'(1);
            end
          end
        end
        S_RD0:  state_q <= S_CAP0;
        S_CAP0: begin
          i_q <= '0;
          e_q <= '0;
          state_q <= (k_eff == KW'(1)) ? S_EMIT : S_RDP;
        end
        S_RDP:  state_q <= S_CAND;
        S_CAND: begin
          j_q     <= '0;
          state_q <= S_DST;
        end
        S_DST:  state_q <= S_DWT;
        S_DWT: begin
          if (dist_done) begin
            if (j_q == s_q - SIW'(1)) begin
              state_q <= S_NEXT;
            end else begin
              j_q     <= j_q + SIW'(1);
              state_q <= S_DST;
            end
          end
        end
        S_NEXT: begin
          if ({1'b0, i_q} == n_eff - PW'(1)) begin
            state_q <= S_RDB;
          end else begin
            i_q     <= i_q + IW'(1);
            state_q <= S_RDP;
          end
        end
        S_RDB:  state_q <= S_CAPB;
        S_CAPB: begin
          i_q <= '0;
          e_q <= '0;
          if ({1'b0, s_q} == (SIW+1)'(k_eff - KW'(1))) begin
            state_q <= S_EMIT;
          end else begin
            s_q     <= s_q + SIW'(1);
            state_q <= S_RDP;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (e_last) begin
              load_cnt_q <= '0;
              state_q    <= S_IDLE;
            end else begin
              e_q <= e_q + SIW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the search and the output word.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_CAP0: begin
        seed_crd_q[0] <= rd_q;
        seed_idx_q[0] <= '0;
        best_q        <= '0;
        bidx_q        <= '0;
      end
      S_CAND: begin
        cand_q <= rd_q;
        sum_q  <= '0;
      end
      S_DWT: begin
        if (dist_done) sum_q <= sum_q + SMW'(dist_val);
      end
      S_NEXT: begin
        if (sum_q > best_q) begin
          best_q <= sum_q;
          bidx_q <= i_q;
        end
      end
      S_CAPB: begin
        seed_crd_q[s_q] <= rd_q;
        seed_idx_q[s_q] <= bidx_q;
        best_q          <= '0;
        bidx_q          <= '0;
      end
      S_EMIT: begin
        if (out_load) begin
          point_index_o <= fpss_pkg::IndexOutW'(seed_idx_q[e_q]);
          out_x_o       <= seed_crd[0*COORD_BITS +: COORD_BITS];
          out_y_o       <= seed_crd[1*COORD_BITS +: COORD_BITS];
          out_z_o       <= seed_crd[2*COORD_BITS +: COORD_BITS];
          out_w_o       <= seed_crd[3*COORD_BITS +: COORD_BITS];
          last_of_run_o <= e_last;
        end
      end
      default: ;
    endcase
  end

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_done |-> (state_q == S_DWT))
    else $error("distance result outside its wait state");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDB) |-> ({1'b0, bidx_q} < n_eff))
    else $error("chosen seed beyond the searched points");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && e_last) |=> (state_q == S_IDLE) && last_of_run_o)
    else $error("run did not end after its final seed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("pending seed word dropped");

endmodule

[verif/tb_farthest_point_seed_select_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for the farthest-point seed selection core.
module tb_farthest_point_seed_select_core;

  localparam int unsigned StoreDepth = 256;
  localparam int unsigned SeedMax    = 8;
  localparam int unsigned SettleCyc  = 20;

  typedef struct {
    logic               op;
    logic signed [15:0] c [4];
  } point_word_t;

  typedef struct {
    logic [7:0]         idx;
    logic signed [15:0] c [4];
    logic               last;
  } seed_word_t;

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_idx_i;
  logic [fpss_pkg::CfgDataW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o, operation_i;
  logic signed [15:0] in_x_i, in_y_i, in_z_i, in_w_i;
  logic out_valid_o, out_ready_i;
  logic [fpss_pkg::IndexOutW-1:0] point_index_o;
  logic signed [15:0] out_x_o, out_y_o, out_z_o, out_w_o;
  logic last_of_run_o;

  farthest_point_seed_select_core dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  point_word_t pending_words[$];
  seed_word_t  seeds_due[$];
  int          mismatches = 0;
  int          loads_sent = 0, runs_sent = 0, seeds_seen = 0;
  bit          quiet = 1'b0;

  // Shadow copy of the block's state.
  logic signed [15:0] shadow_pts [StoreDepth][4];
  int unsigned        shadow_load_ptr = 0;
  logic [8:0]         shadow_num_points = 9'd150;
  logic [3:0]         shadow_num_select = 4'd3;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned pair_distance(int unsigned a, int unsigned b);
    longint unsigned acc = 0;
    longint unsigned m;
    int d;
    for (int c = 0; c < 4; c++) begin
      d = int'(shadow_pts[a][c]) - int'(shadow_pts[b][c]);
      m = (d < 0) ? longint'(-d) : longint'(d);
      acc += m * m;
    end
    return int_sqrt(acc);
  endfunction

  task automatic predict_word(point_word_t w);
    int unsigned n, k, best;
    int unsigned seeds [SeedMax];
    longint unsigned best_sum, sum;
    seed_word_t r;
    if (w.op == fpss_pkg::OP_LOAD) begin
      if (shadow_load_ptr < StoreDepth) begin
        for (int c = 0; c < 4; c++) shadow_pts[shadow_load_ptr][c] = w.c[c];
        shadow_load_ptr++;
      end
      return;
    end
    n = shadow_num_points;
    if (n < 1) n = 1;
    if (n > StoreDepth) n = StoreDepth;
    k = shadow_num_select;
    if (k < 1) k = 1;
    if (k > SeedMax) k = SeedMax;
    seeds[0] = 0;
    for (int s = 1; s < k; s++) begin
      best_sum = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        sum = 0;
        for (int j = 0; j < s; j++) sum += pair_distance(i, seeds[j]);
        if (sum > best_sum) begin
          best_sum = sum;
          best = i;
        end
      end
      seeds[s] = best;
    end
    shadow_load_ptr = 0;
    for (int s = 0; s < k; s++) begin
      r.idx = seeds[s][7:0];
      for (int c = 0; c < 4; c++) r.c[c] = shadow_pts[seeds[s]][c];
      r.last = (s + 1 == k);
      seeds_due.push_back(r);
    end
  endtask

  // Input driver.
  point_word_t cur_word;
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= fpss_pkg::OP_LOAD;
      in_x_i <= '0; in_y_i <= '0; in_z_i <= '0; in_w_i <= '0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_word(cur_word);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          operation_i <= cur_word.op;
          in_x_i <= cur_word.c[0];
          in_y_i <= cur_word.c[1];
          in_z_i <= cur_word.c[2];
          in_w_i <= cur_word.c[3];
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 13);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random back-pressure.
  int out_stall = 0;
  seed_word_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seeds_seen++;
        if (seeds_due.size() == 0) begin
          $error("unexpected seed word, point_index %0d", point_index_o);
          mismatches++;
        end else begin
          want = seeds_due.pop_front();
          if (point_index_o !== want.idx) begin
            $error("point_index expected %0d actual %0d", want.idx, point_index_o);
            mismatches++;
          end
          if (out_x_o !== want.c[0]) begin
            $error("out_x expected %0d actual %0d", want.c[0], out_x_o);
            mismatches++;
          end
          if (out_y_o !== want.c[1]) begin
            $error("out_y expected %0d actual %0d", want.c[1], out_y_o);
            mismatches++;
          end
          if (out_z_o !== want.c[2]) begin
            $error("out_z expected %0d actual %0d", want.c[2], out_z_o);
            mismatches++;
          end
          if (out_w_o !== want.c[3]) begin
            $error("out_w expected %0d actual %0d", want.c[3], out_w_o);
            mismatches++;
          end
          if (last_of_run_o !== want.last) begin
            $error("last_of_run expected %0d actual %0d", want.last, last_of_run_o);
            mismatches++;
          end
        end
      end
      if (quiet) begin
        out_ready_i <= 1'b1;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 4) == 0) out_stall = $urandom_range(1, 13);
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || seeds_due.size() != 0);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [fpss_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == fpss_pkg::REG_NUM_POINTS) shadow_num_points = val[8:0];
    else shadow_num_select = val[3:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(int unsigned np, int unsigned ns);
    wait_idle();
    write_reg(fpss_pkg::REG_NUM_POINTS, fpss_pkg::CfgDataW'(np));
    write_reg(fpss_pkg::REG_NUM_SELECT, fpss_pkg::CfgDataW'(ns));
  endtask

  task automatic push_load(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic signed [15:0] w);
    point_word_t p;
    p.op = fpss_pkg::OP_LOAD;
    p.c[0] = x; p.c[1] = y; p.c[2] = z; p.c[3] = w;
    pending_words.push_back(p);
    loads_sent++;
  endtask

  task automatic push_run();
    point_word_t p;
    p.op = fpss_pkg::OP_RUN;
    for (int c = 0; c < 4; c++) p.c[c] = 16'($urandom);
    pending_words.push_back(p);
    runs_sent++;
  endtask

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_random_loads(int unsigned cnt);
    for (int i = 0; i < cnt; i++)
      push_load(pick_coord(), pick_coord(), pick_coord(), pick_coord());
  endtask

  int unsigned slots_written = 0;
  int unsigned np, ns, n_eff, nloads, phase;

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = fpss_pkg::REG_NUM_POINTS;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, more seeds than points, so seeds repeat.
    set_config(4, 8);
    push_load(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    push_load(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_load(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    push_load(16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF);
    push_run();
    // All points equal: every sum is zero and index 0 wins each time.
    set_config(3, 2);
    for (int i = 0; i < 3; i++) push_load(16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100);
    push_run();
    // Zero point and seed counts are taken as one; a run with no loads since the last.
    set_config(0, 0);
    push_run();
    // Seed count above the maximum saturates; ties between equal distances.
    set_config(4, 15);
    push_load(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    push_load(16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000);
    push_load(16'shFF00, 16'sh0000, 16'sh0000, 16'sh0000);
    push_load(16'sh0000, 16'sh0100, 16'sh0000, 16'sh0000);
    push_run();
    slots_written = 4;

    // One deeper run with every seed over a larger set of points.
    set_config(48, 8);
    push_random_loads(48);
    push_run();
    slots_written = 48;

    phase = 0;
    while (loads_sent + runs_sent < 220) begin
      if (loads_sent + runs_sent > 185) quiet = 1'b1;
      if ($urandom_range(0, 1) == 0 || phase == 0) begin
        np = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        ns = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        set_config(np, ns);
      end
      n_eff = (shadow_num_points < 1) ? 1 : shadow_num_points;
      // Mostly a fresh batch of points; sometimes a run on what is already stored.
      if ($urandom_range(0, 4) == 0 && slots_written >= n_eff) nloads = $urandom_range(0, 3);
      else nloads = n_eff + $urandom_range(0, 4);
      push_random_loads(nloads);
      if (nloads > slots_written) slots_written = nloads;
      push_run();
      if ($urandom_range(0, 5) == 0) push_run();
      phase++;
    end

    wait_idle();
    repeat (50) @(negedge clk_i);
    $display("Covered %0d loads and %0d runs, %0d seed words checked.",
             loads_sent, runs_sent, seeds_seen);
    if (mismatches == 0 && seeds_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
